// File: design/pixel_block_report_packetizer_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the pixel block report packetizer
// Clocked implication checks with synchronous reset masking.
// ---------------------------------------------------------------------------
`ifndef PIXEL_BLOCK_REPORT_PACKETIZER_MACROS_SVH
`define PIXEL_BLOCK_REPORT_PACKETIZER_MACROS_SVH

// same-cycle implication
`define PBRP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PBRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/pbrp_pkg.sv
// ---------------------------------------------------------------------------
// pbrp_pkg
// Shared constants, codes and types of the pixel block report packetizer.
// ---------------------------------------------------------------------------
`default_nettype none

package pbrp_pkg;

  localparam int REPORT_BYTES = 65;
  localparam int PANEL_WIDTH  = 256;
  localparam int PANEL_HEIGHT = 64;

  localparam int FIRST_HDR = 10;
  localparam int CONT_HDR  = 2;
  localparam int FIRST_CAP = REPORT_BYTES - FIRST_HDR;
  localparam int CONT_CAP  = ((REPORT_BYTES - 2) < 63) ? (REPORT_BYTES - 2) : 63;

  localparam logic [7:0] PANEL_W8 = 8'(PANEL_WIDTH % 256);
  localparam logic [7:0] PANEL_H8 = 8'(PANEL_HEIGHT % 256);

  localparam logic [7:0] REPORT_ID  = 8'h00;
  localparam logic [7:0] CMD_BYTE0  = 8'h1B;
  localparam logic [7:0] CMD_BYTE1  = 8'h5B;
  localparam logic [7:0] CMD_BYTE2  = 8'hF0;
  localparam logic [7:0] LEN_FULL   = 8'd64;
  localparam logic [7:0] FIRST_BIAS = 8'h08;

  localparam int STEP_W = 4;

  // header byte slots of the first report
  localparam logic [STEP_W-1:0] HDR_ID      = 4'd0;
  localparam logic [STEP_W-1:0] HDR_LEN     = 4'd1;
  localparam logic [STEP_W-1:0] HDR_CMD0    = 4'd2;
  localparam logic [STEP_W-1:0] HDR_CMD1    = 4'd3;
  localparam logic [STEP_W-1:0] HDR_CMD2    = 4'd4;
  localparam logic [STEP_W-1:0] HDR_X       = 4'd5;
  localparam logic [STEP_W-1:0] HDR_Y       = 4'd6;
  localparam logic [STEP_W-1:0] HDR_HEIGHT  = 4'd7;
  localparam logic [STEP_W-1:0] HDR_SIZE_HI = 4'd8;
  localparam logic [STEP_W-1:0] HDR_SIZE_LO = 4'd9;

  localparam logic [STEP_W-1:0] STEP_START    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_CONT_LEN = 4'd1;

  typedef enum logic [1:0] {
    CFG_OFFSCREEN_MODE = 2'd0,
    CFG_DISPLAY_X      = 2'd1,
    CFG_DISPLAY_Y      = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    KIND_HDR,
    KIND_CONT_ZERO,
    KIND_CONT_LEN,
    KIND_DATA,
    KIND_DROP
  } beat_kind_t;

  typedef struct packed {
    logic       offscreen_mode;
    logic [7:0] display_x;
    logic [7:0] display_y;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [7:0]  block_x;
    logic [7:0]  block_y;
    logic [7:0]  block_height;
    logic [15:0] block_size;
  } pix_item_t;

  typedef struct packed {
    logic [7:0] report_byte;
    logic [6:0] report_position;
    logic       report_end;
    logic       block_end;
    logic       last;
  } report_beat_t;

endpackage

`default_nettype wire

// File: design/pbrp_if.sv
// ---------------------------------------------------------------------------
// pbrp_if
// Valid/ready channels for pixel bytes in and report bytes out.
// ---------------------------------------------------------------------------
`default_nettype none

interface pbrp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic [7:0]  block_x;
  logic [7:0]  block_y;
  logic [7:0]  block_height;
  logic [15:0] block_size;

  modport source (output valid, data_byte, first_byte, block_x, block_y, block_height,
                  block_size, input ready);
  modport sink (input valid, data_byte, first_byte, block_x, block_y, block_height,
                block_size, output ready);
endinterface

interface pbrp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] report_byte;
  logic [6:0] report_position;
  logic       report_end;
  logic       block_end;
  logic       last;

  modport source (output valid, report_byte, report_position, report_end, block_end, last,
                  input ready);
  modport sink (input valid, report_byte, report_position, report_end, block_end, last,
                output ready);
endinterface

`default_nettype wire

// File: design/pixel_block_report_packetizer.sv
// A byte's first result goes via the item register and beat decode to the output register.
// A mid-report data byte gives one data beat; a first byte gives 10 header beats, then data
// (only the headers for an empty block); a byte opening a continuation report gives id and
// length beats, then data; a stray byte is dropped. Next byte is taken as the last beat moves.
// Reset (rst, synchronous): channels empty, block state zero, offscreen_mode 1, display 0,0.
// ---------------------------------------------------------------------------
// pixel_block_report_packetizer
// Packs pixel block bytes into device report beats with first and continuation headers.
// ---------------------------------------------------------------------------
`default_nettype none

module pixel_block_report_packetizer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  pbrp_in_if.sink          pix_in,
  pbrp_out_if.source       rep_out
);

  pbrp_pkg::cfg_t         cfg;
  pbrp_pkg::pix_item_t    in_item;
  pbrp_pkg::report_beat_t beat;
  logic                   emit;
  logic                   out_free;
  logic                   in_ready;

  assign in_item.data_byte    = pix_in.data_byte;
  assign in_item.first_byte   = pix_in.first_byte;
  assign in_item.block_x      = pix_in.block_x;
  assign in_item.block_y      = pix_in.block_y;
  assign in_item.block_height = pix_in.block_height;
  assign in_item.block_size   = pix_in.block_size;
  assign pix_in.ready         = in_ready;

  pbrp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pbrp_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (pix_in.valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_free (out_free),
    .emit     (emit),
    .beat     (beat)
  );

  pbrp_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .emit     (emit),
    .beat     (beat),
    .out_free (out_free),
    .rep_out  (rep_out)
  );

endmodule

`default_nettype wire

// File: design/pbrp_cfg_regs.sv
// ---------------------------------------------------------------------------
// pbrp_cfg_regs
// Configuration registers: off-screen mode and display window origin.
// ---------------------------------------------------------------------------
`default_nettype none

module pbrp_cfg_regs (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [7:0]          cfg_data,
  output pbrp_pkg::cfg_t           cfg
);

  pbrp_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.offscreen_mode <= 1'b1;
      regs.display_x      <= 8'd0;
      regs.display_y      <= 8'd0;
    end else if (cfg_wr_en) begin
      unique case (pbrp_pkg::cfg_index_t'(cfg_index))
        pbrp_pkg::CFG_OFFSCREEN_MODE: regs.offscreen_mode <= cfg_data[0];
        pbrp_pkg::CFG_DISPLAY_X:      regs.display_x      <= cfg_data;
        pbrp_pkg::CFG_DISPLAY_Y:      regs.display_y      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

// File: design/pbrp_seq.sv
// ---------------------------------------------------------------------------
// pbrp_seq
// Item register, block state and the decode of the next report beat.
// ---------------------------------------------------------------------------
`default_nettype none

module pbrp_seq (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire pbrp_pkg::cfg_t      cfg,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire pbrp_pkg::pix_item_t in_item,
  input  wire logic                out_free,
  output logic                     emit,
  output pbrp_pkg::report_beat_t   beat
);

  pbrp_pkg::pix_item_t           item;
  logic                          busy;
  logic [pbrp_pkg::STEP_W-1:0]   step;
  logic [15:0]                   bytes_left;
  logic [6:0]                    report_fill;
  logic [6:0]                    report_capacity;

  pbrp_pkg::beat_kind_t kind;
  logic        adv;
  logic        done;
  logic        first_fits;
  logic [6:0]  first_cap;
  logic [7:0]  first_len;
  logic        cont_fits;
  logic [6:0]  cont_data;
  logic [7:0]  cont_len;
  logic [15:0] left_dec;
  logic [7:0]  pos_x;
  logic [7:0]  pos_y;
  logic [7:0]  hdr_byte;
  logic        size_zero;

  always_comb begin
    first_fits = item.block_size <= 16'(pbrp_pkg::FIRST_CAP);
    first_cap  = first_fits ? 7'(pbrp_pkg::FIRST_HDR) + item.block_size[6:0]
                            : 7'(pbrp_pkg::REPORT_BYTES);
    first_len  = first_fits ? item.block_size[7:0] + pbrp_pkg::FIRST_BIAS
                            : pbrp_pkg::LEN_FULL;
    cont_fits  = bytes_left <= 16'(pbrp_pkg::CONT_CAP);
    cont_data  = cont_fits ? bytes_left[6:0] : 7'(pbrp_pkg::CONT_CAP);
    cont_len   = cont_fits ? bytes_left[7:0] : pbrp_pkg::LEN_FULL;
    left_dec   = bytes_left - 16'd1;
    size_zero  = item.block_size == 16'd0;
    // off-screen translation wraps at 8 bits
    pos_x = cfg.offscreen_mode ? item.block_x + pbrp_pkg::PANEL_W8 - cfg.display_x
                               : item.block_x;
    pos_y = cfg.offscreen_mode ? item.block_y + pbrp_pkg::PANEL_H8 - cfg.display_y
                               : item.block_y;
  end

  always_comb begin
    unique case (step)
      pbrp_pkg::HDR_ID:      hdr_byte = pbrp_pkg::REPORT_ID;
      pbrp_pkg::HDR_LEN:     hdr_byte = first_len;
      pbrp_pkg::HDR_CMD0:    hdr_byte = pbrp_pkg::CMD_BYTE0;
      pbrp_pkg::HDR_CMD1:    hdr_byte = pbrp_pkg::CMD_BYTE1;
      pbrp_pkg::HDR_CMD2:    hdr_byte = pbrp_pkg::CMD_BYTE2;
      pbrp_pkg::HDR_X:       hdr_byte = pos_x;
      pbrp_pkg::HDR_Y:       hdr_byte = pos_y;
      pbrp_pkg::HDR_HEIGHT:  hdr_byte = item.block_height;
      pbrp_pkg::HDR_SIZE_HI: hdr_byte = item.block_size[15:8];
      pbrp_pkg::HDR_SIZE_LO: hdr_byte = item.block_size[7:0];
      default:               hdr_byte = pbrp_pkg::REPORT_ID;
    endcase
  end

  // what this step of the held item produces
  always_comb begin
    if (item.first_byte) begin
      kind = (step < 4'(pbrp_pkg::FIRST_HDR)) ? pbrp_pkg::KIND_HDR : pbrp_pkg::KIND_DATA;
    end else begin
      priority case (step)
        pbrp_pkg::STEP_START: begin
          if (bytes_left == 16'd0) begin
            kind = pbrp_pkg::KIND_DROP;
          end else if (report_fill >= report_capacity) begin
            kind = pbrp_pkg::KIND_CONT_ZERO;
          end else begin
            kind = pbrp_pkg::KIND_DATA;
          end
        end
        pbrp_pkg::STEP_CONT_LEN: kind = pbrp_pkg::KIND_CONT_LEN;
        default:                 kind = pbrp_pkg::KIND_DATA;
      endcase
    end
  end

  always_comb begin
    beat = '0;
    emit = 1'b1;
    unique case (kind)
      pbrp_pkg::KIND_HDR: begin
        beat.report_byte     = hdr_byte;
        beat.report_position = 7'(step);
        beat.report_end      = (7'(step) + 7'd1) == first_cap;
        beat.block_end       = size_zero && (step == pbrp_pkg::HDR_SIZE_LO);
        beat.last            = size_zero && (step == pbrp_pkg::HDR_SIZE_LO);
      end
      pbrp_pkg::KIND_CONT_ZERO: begin
        beat.report_byte     = pbrp_pkg::REPORT_ID;
        beat.report_position = 7'd0;
      end
      pbrp_pkg::KIND_CONT_LEN: begin
        beat.report_byte     = cont_len;
        beat.report_position = 7'd1;
      end
      pbrp_pkg::KIND_DATA: begin
        beat.report_byte     = item.data_byte;
        beat.report_position = report_fill;
        beat.report_end      = (report_fill + 7'd1) == report_capacity;
        beat.block_end       = left_dec == 16'd0;
        beat.last            = 1'b1;
      end
      pbrp_pkg::KIND_DROP: emit = 1'b0;
      default:             emit = 1'b0;
    endcase
    emit = emit && busy;
  end

  assign adv      = busy && out_free;
  assign done     = (kind == pbrp_pkg::KIND_DROP) || beat.last;
  assign in_ready = !busy || (adv && done);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy            <= 1'b0;
      step            <= '0;
      bytes_left      <= 16'd0;
      report_fill     <= 7'd0;
      report_capacity <= 7'd0;
    end else begin
      if (in_valid && in_ready) begin
        busy <= 1'b1;
        step <= '0;
      end else if (adv) begin
        if (done) begin
          busy <= 1'b0;
        end else begin
          step <= step + 4'd1;
        end
      end
      if (adv) begin
        unique case (kind)
          pbrp_pkg::KIND_HDR: begin
            if (step == pbrp_pkg::HDR_SIZE_LO) begin
              bytes_left      <= item.block_size;
              report_fill     <= 7'(pbrp_pkg::FIRST_HDR);
              report_capacity <= first_cap;
            end
          end
          pbrp_pkg::KIND_CONT_ZERO: begin
            report_fill     <= 7'd1;
            report_capacity <= 7'(pbrp_pkg::CONT_HDR) + cont_data;
          end
          pbrp_pkg::KIND_CONT_LEN: report_fill <= 7'(pbrp_pkg::CONT_HDR);
          pbrp_pkg::KIND_DATA: begin
            bytes_left  <= left_dec;
            report_fill <= report_fill + 7'd1;
          end
          pbrp_pkg::KIND_DROP: ;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// File: design/pbrp_out_reg.sv
// ---------------------------------------------------------------------------
// pbrp_out_reg
// Result register between the beat decode and the report channel.
// ---------------------------------------------------------------------------
`default_nettype none

module pbrp_out_reg (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   emit,
  input  wire pbrp_pkg::report_beat_t beat,
  output logic                        out_free,
  pbrp_out_if.source                  rep_out
);

  logic                   valid;
  pbrp_pkg::report_beat_t held;

  assign out_free = !valid || rep_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (out_free) begin
      valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      held <= beat;
    end
  end

  assign rep_out.valid           = valid;
  assign rep_out.report_byte     = held.report_byte;
  assign rep_out.report_position = held.report_position;
  assign rep_out.report_end      = held.report_end;
  assign rep_out.block_end       = held.block_end;
  assign rep_out.last            = held.last;

endmodule

`default_nettype wire

// File: design/pbrp_checker.sv
// ---------------------------------------------------------------------------
// pbrp_checker
// Port-level checks on the report channel, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "pixel_block_report_packetizer_macros.svh"

module pbrp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       valid,
  input wire logic       ready,
  input wire logic [7:0] report_byte,
  input wire logic [6:0] report_position,
  input wire logic       report_end,
  input wire logic       block_end,
  input wire logic       last
);

  `PBRP_ASSERT_NEXT(a_hold_valid, clk, rst, valid && !ready, valid, "beat dropped while stalled")
  `PBRP_ASSERT_NOW(a_pos_range, clk, rst, valid, report_position < 7'(pbrp_pkg::REPORT_BYTES), "report position out of range")
  `PBRP_ASSERT_NOW(a_block_end, clk, rst, valid && block_end, report_end && last, "block end without report end and last")
  `PBRP_ASSERT_NOW(a_report_open, clk, rst, valid && report_position == 7'd0, report_byte == pbrp_pkg::REPORT_ID && !report_end, "report does not open with id byte")

endmodule

bind pixel_block_report_packetizer pbrp_checker u_pbrp_checker (
  .clk             (clk),
  .rst             (rst),
  .valid           (rep_out.valid),
  .ready           (rep_out.ready),
  .report_byte     (rep_out.report_byte),
  .report_position (rep_out.report_position),
  .report_end      (rep_out.report_end),
  .block_end       (rep_out.block_end),
  .last            (rep_out.last)
);

`default_nettype wire
